// ----- rtl/mer_pkg.sv -----
package mer_pkg;

    // input command codes
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // quadrant of the fourth (last) point of a run
    localparam logic [1:0] QUAD_LAST = 2'd3;

    typedef enum logic [14:0] {
        ST_IDLE  = 15'b000_0000_0000_0001,
        ST_SQA   = 15'b000_0000_0000_0010,
        ST_SQB   = 15'b000_0000_0000_0100,
        ST_RXB   = 15'b000_0000_0000_1000,
        ST_INIT1 = 15'b000_0000_0001_0000,
        ST_T2    = 15'b000_0000_0010_0000,
        ST_RA    = 15'b000_0000_0100_0000,
        ST_U2    = 15'b000_0000_1000_0000,
        ST_RB    = 15'b000_0001_0000_0000,
        ST_RC    = 15'b000_0010_0000_0000,
        ST_RD    = 15'b000_0100_0000_0000,
        ST_ROUND = 15'b000_1000_0000_0000,
        ST_STEP1 = 15'b001_0000_0000_0000,
        ST_STEP2 = 15'b010_0000_0000_0000,
        ST_EMIT  = 15'b100_0000_0000_0000
    } state_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_R1   = 3'b010,
        PH_R2   = 3'b100
    } phase_t;

    // multiplier operand selection
    typedef enum logic [3:0] {
        MUL_NONE = 4'd0,
        MUL_AA   = 4'd1,
        MUL_BB   = 4'd2,
        MUL_RXB  = 4'd3,
        MUL_TT   = 4'd4,
        MUL_RYP  = 4'd5,
        MUL_UU   = 4'd6,
        MUL_RXP  = 4'd7,
        MUL_RXRY = 4'd8
    } mul_sel_t;

    // datapath register update
    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_RX2   = 4'd1,
        OP_RY2   = 4'd2,
        OP_INIT1 = 4'd3,
        OP_DLOAD = 4'd4,
        OP_DADD4 = 4'd5,
        OP_DSUB4 = 4'd6,
        OP_ROUND = 4'd7,
        OP_STEP1 = 4'd8,
        OP_STEP2 = 4'd9
    } dp_op_t;

    typedef struct packed {
        logic       load;
        mul_sel_t   mul_sel;
        dp_op_t     op;
        logic       region2;
        logic       out_load;
        logic [1:0] out_quad;
        logic       out_last;
    } mer_cmd_t;

    typedef struct packed {
        logic grad_less;
        logic y_zero;
    } mer_status_t;

endpackage

// ----- rtl/mer_ctrl.sv -----
module mer_ctrl
    import mer_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        command,
    input  logic        out_ready,
    input  mer_status_t status,
    output logic        in_ready,
    output logic        out_valid,
    output mer_cmd_t    cmd
);

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [1:0] quad_reg, quad_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        quad_next     = quad_reg;
        cmd.load      = 1'b0;
        cmd.mul_sel   = MUL_NONE;
        cmd.op        = OP_NONE;
        cmd.region2   = (phase_reg == PH_R2);
        cmd.out_load  = 1'b0;
        cmd.out_quad  = quad_reg;
        cmd.out_last  = (quad_reg == QUAD_LAST);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == CMD_START)
                    begin
                        cmd.load   = 1'b1;
                        phase_next = PH_R1;
                        state_next = ST_SQA;
                    end
                    else if (phase_reg == PH_R1 && status.grad_less)
                    begin
                        state_next = ST_STEP1;
                    end
                    else if (phase_reg == PH_R1)
                    begin
                        phase_next = PH_R2;
                        state_next = ST_T2;
                    end
                    else if (phase_reg == PH_R2)
                    begin
                        state_next = ST_STEP1;
                    end
                    // advance while idle: drop the item
                end
            end
            ST_SQA:
            begin
                cmd.mul_sel = MUL_AA;
                state_next  = ST_SQB;
            end
            ST_SQB:
            begin
                cmd.mul_sel = MUL_BB;
                cmd.op      = OP_RX2;
                state_next  = ST_RXB;
            end
            ST_RXB:
            begin
                cmd.mul_sel = MUL_RXB;
                cmd.op      = OP_RY2;
                state_next  = ST_INIT1;
            end
            ST_INIT1:
            begin
                cmd.op     = OP_INIT1;
                state_next = ST_ROUND;
            end
            ST_T2:
            begin
                cmd.mul_sel = MUL_TT;
                state_next  = ST_RA;
            end
            ST_RA:
            begin
                cmd.mul_sel = MUL_RYP;
                state_next  = ST_U2;
            end
            ST_U2:
            begin
                cmd.mul_sel = MUL_UU;
                cmd.op      = OP_DLOAD;
                state_next  = ST_RB;
            end
            ST_RB:
            begin
                cmd.mul_sel = MUL_RXP;
                state_next  = ST_RC;
            end
            ST_RC:
            begin
                cmd.mul_sel = MUL_RXRY;
                cmd.op      = OP_DADD4;
                state_next  = ST_RD;
            end
            ST_RD:
            begin
                cmd.op     = OP_DSUB4;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.op = OP_ROUND;
                // a start run goes straight to output, region change takes a step
                state_next = (phase_reg == PH_R1) ? ST_EMIT : ST_STEP1;
            end
            ST_STEP1:
            begin
                cmd.op     = OP_STEP1;
                state_next = ST_STEP2;
            end
            ST_STEP2:
            begin
                cmd.op     = OP_STEP2;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    quad_next    = quad_reg + 2'd1;
                    if (quad_reg == QUAD_LAST)
                    begin
                        state_next = ST_IDLE;
                        if (status.y_zero)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                phase_next = PH_IDLE;
                quad_next  = 2'd0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_IDLE;
            quad_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            quad_reg      <= quad_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/mer_dpath.sv -----
module mer_dpath
    import mer_pkg::*;
#(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10
)
(
    input  logic                         clk,
    input  mer_cmd_t                     cmd,
    input  logic signed [COORD_BITS-1:0] centre_x,
    input  logic signed [COORD_BITS-1:0] centre_y,
    input  logic [RADIUS_BITS-1:0]       radius_x,
    input  logic [RADIUS_BITS-1:0]       radius_y,
    output mer_status_t                  status,
    output logic signed [COORD_BITS:0]   point_x,
    output logic signed [COORD_BITS:0]   point_y,
    output logic                         last_in_run,
    output logic                         figure_done
);

    localparam int RW  = RADIUS_BITS;
    localparam int XW  = RADIUS_BITS + 1;
    localparam int SQW = 2 * RADIUS_BITS;
    localparam int GW  = 3 * RADIUS_BITS + 2;
    localparam int MA  = 2 * RADIUS_BITS + 4;
    localparam int PW  = 2 * MA;
    localparam int DW  = 4 * RADIUS_BITS + 6;
    localparam int SW  = ((COORD_BITS > RADIUS_BITS + 2) ? COORD_BITS : RADIUS_BITS + 2) + 1;

    logic [RW-1:0]                 a_reg, b_reg;
    logic signed [COORD_BITS-1:0]  cx_reg, cy_reg;
    logic [SQW-1:0]                rx2_reg, ry2_reg;
    logic [XW-1:0]                 x_reg;
    logic [RW-1:0]                 y_reg;
    logic [GW-1:0]                 gx_reg, gy_reg;
    logic signed [DW-1:0]          d_reg;
    logic [PW-1:0]                 prod_reg, prod_next;
    logic                          use_gx_reg, use_gy_reg;
    logic signed [COORD_BITS:0]    point_x_reg, point_y_reg;
    logic                          last_reg, done_reg;

    logic [MA-1:0]        ma, mb;
    logic [RW+1:0]        t_val;
    logic [RW-1:0]        u_val;
    logic signed [DW-1:0] prod_d, prod4_d, rx2_d, ry2_d, ry2x4_d, gx_d, gy_d;
    logic signed [DW-1:0] rnd_sum, step_base, step_gx, step_gy;
    logic                 dec_neg, inc_x, dec_y;
    logic signed [SW-1:0] cx_e, cy_e, x_e, y_e, px, py;

    assign t_val = {x_reg, 1'b1};
    assign u_val = y_reg - RW'(1);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_AA:   begin ma = MA'(a_reg);   mb = MA'(a_reg);   end
            MUL_BB:   begin ma = MA'(b_reg);   mb = MA'(b_reg);   end
            MUL_RXB:  begin ma = MA'(rx2_reg); mb = MA'(b_reg);   end
            MUL_TT:   begin ma = MA'(t_val);   mb = MA'(t_val);   end
            MUL_RYP:  begin ma = MA'(ry2_reg); mb = prod_reg[MA-1:0]; end
            MUL_UU:   begin ma = MA'(u_val);   mb = MA'(u_val);   end
            MUL_RXP:  begin ma = MA'(rx2_reg); mb = prod_reg[MA-1:0]; end
            MUL_RXRY: begin ma = MA'(rx2_reg); mb = MA'(ry2_reg); end
            default:  begin ma = '0;           mb = '0;           end
        endcase
    end

    assign prod_next = PW'(ma) * PW'(mb);

    assign prod_d  = signed'({1'b0, prod_reg[DW-2:0]});
    assign prod4_d = signed'({1'b0, prod_reg[DW-4:0], 2'b00});
    assign rx2_d   = signed'(DW'(rx2_reg));
    assign ry2_d   = signed'(DW'(ry2_reg));
    assign ry2x4_d = signed'(DW'({ry2_reg, 2'b00}));
    assign gx_d    = signed'(DW'(gx_reg));
    assign gy_d    = signed'(DW'(gy_reg));

    // quarter with rounding half away from zero
    assign rnd_sum = d_reg + (d_reg[DW-1] ? DW'(1) : DW'(2));

    assign dec_neg = d_reg[DW-1];
    assign inc_x   = !cmd.region2 || dec_neg;
    assign dec_y   = cmd.region2 || !dec_neg;

    assign step_base = cmd.region2 ? rx2_d : ry2_d;
    assign step_gx   = use_gx_reg ? gx_d : '0;
    assign step_gy   = use_gy_reg ? gy_d : '0;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;

        if (cmd.load)
        begin
            a_reg  <= radius_x;
            b_reg  <= radius_y;
            cx_reg <= centre_x;
            cy_reg <= centre_y;
            x_reg  <= '0;
            y_reg  <= radius_y;
            gx_reg <= '0;
        end

        case (cmd.op)
            OP_RX2:   rx2_reg <= prod_reg[SQW-1:0];
            OP_RY2:   ry2_reg <= prod_reg[SQW-1:0];
            OP_INIT1:
            begin
                gy_reg <= {prod_reg[GW-2:0], 1'b0};
                d_reg  <= ry2x4_d + rx2_d - prod4_d;
            end
            OP_DLOAD: d_reg <= prod_d;
            OP_DADD4: d_reg <= d_reg + prod4_d;
            OP_DSUB4: d_reg <= d_reg - prod4_d;
            OP_ROUND: d_reg <= rnd_sum >>> 2;
            OP_STEP1:
            begin
                if (inc_x)
                begin
                    x_reg  <= x_reg + XW'(1);
                    gx_reg <= gx_reg + GW'({ry2_reg, 1'b0});
                end
                if (dec_y)
                begin
                    y_reg  <= y_reg - RW'(1);
                    gy_reg <= gy_reg - GW'({rx2_reg, 1'b0});
                end
                use_gx_reg <= inc_x;
                use_gy_reg <= dec_y;
            end
            OP_STEP2: d_reg <= d_reg + step_base + step_gx - step_gy;
            default:  ;
        endcase

        if (cmd.out_load)
        begin
            point_x_reg <= px[COORD_BITS:0];
            point_y_reg <= py[COORD_BITS:0];
            last_reg    <= cmd.out_last;
            done_reg    <= status.y_zero;
        end
    end

    // quadrant bit 0 mirrors x, bit 1 mirrors y
    assign cx_e = SW'(cx_reg);
    assign cy_e = SW'(cy_reg);
    assign x_e  = signed'(SW'(x_reg));
    assign y_e  = signed'(SW'(y_reg));
    assign px   = cmd.out_quad[0] ? (cx_e - x_e) : (cx_e + x_e);
    assign py   = cmd.out_quad[1] ? (cy_e - y_e) : (cy_e + y_e);

    assign status.grad_less = (gx_reg < gy_reg);
    assign status.y_zero    = (y_reg == '0);

    assign point_x     = point_x_reg;
    assign point_y     = point_y_reg;
    assign last_in_run = last_reg;
    assign figure_done = done_reg;

endmodule

// ----- rtl/midpoint_ellipse_rasterizer.sv -----
// Axis-aligned midpoint ellipse rasterizer. A start item (command 0) loads the centre and
// radii and produces four points at the ends of the vertical axis; each advance item
// (command 1) takes one midpoint step and produces the four mirrored points of the new
// position, the fourth flagged last_in_run and all four flagged figure_done on the run
// that reaches y = 0. Advance items with no ellipse in progress are taken and produce
// nothing. One item is in work at a time: the block is not ready again until the last of
// the four points has been loaded into the output register, so an output stall delays it.
// The initial decision values go through a single shared multiplier with a registered
// product, and the four points leave through one output register, one per cycle while
// the output is not stalled.
module midpoint_ellipse_rasterizer
    import mer_pkg::*;
#(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         command,
    input  logic signed [COORD_BITS-1:0] centre_x,
    input  logic signed [COORD_BITS-1:0] centre_y,
    input  logic [RADIUS_BITS-1:0]       radius_x,
    input  logic [RADIUS_BITS-1:0]       radius_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS:0]   point_x,
    output logic signed [COORD_BITS:0]   point_y,
    output logic                         last_in_run,
    output logic                         figure_done
);

    mer_cmd_t    cmd;
    mer_status_t status;

    mer_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .command   (command),
        .out_ready (out_ready),
        .status    (status),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    mer_dpath #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_dpath (
        .clk         (clk),
        .cmd         (cmd),
        .centre_x    (centre_x),
        .centre_y    (centre_y),
        .radius_x    (radius_x),
        .radius_y    (radius_y),
        .status      (status),
        .point_x     (point_x),
        .point_y     (point_y),
        .last_in_run (last_in_run),
        .figure_done (figure_done)
    );

    // never overwrite a point that has not been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || out_ready))
        else $error("output register overwritten while stalled");

    // hold a waiting point until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(point_x) && $stable(point_y)))
        else $error("waiting point dropped or changed");

    // a start item always occupies the block
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && command == CMD_START) |=> !in_ready)
        else $error("start item did not begin work");

endmodule
